FILE: hdl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Types, constants and helpers shared by the full linear convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int OUT_W       = 36;
  localparam int CFG_W       = 5;
  localparam int IDX_W       = 4;
  localparam int TAPS_RESET  = 16;
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int CMP_W       = (TAP_CNT_W > CFG_W) ? TAP_CNT_W : CFG_W;
  localparam int TREE_LEVELS = $clog2(MAX_TAPS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          action;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_sample;
  } flc_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] conv_value;
    logic                    last_result;
  } flc_out_t;

  typedef struct packed {
    logic issue;
    logic clear;
    logic tap_we;
    logic use_tap;
  } flc_cell_ctl_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } flc_state_t;

  // sign extend or wrap a product to the output width
  function automatic logic signed [OUT_W-1:0] fit_out(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W+OUT_W-1:0] w;
    w = (PROD_W + OUT_W)'(p);
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/full_linear_convolution.sv
// ----------------------------------------------------------------------------
// full_linear_convolution
// Streaming full linear convolution of a Q1.15 sample stream with a loaded
// kernel, built as a row of tap cells feeding a registered adder tree.
//
//   channel   signals                             transfer when
//   item      item_valid, item_ready, item        item_valid && item_ready
//   result    result_valid, result_ready, result  result_valid && result_ready
//   config    cfg_we, cfg_wdata                   cfg_we
//
// one item per cycle while item_ready is high; a sample's result is registered in
// the product register and then in each level of the adder tree
// a last sample is followed by one flush step per tap in use beyond the first
// (taps_in_use read as 1..MAX_TAPS); the item channel is held not ready meanwhile
// result backpressure stalls the tree level by level; bubbles are squeezed out
// synchronous reset clears history, pipeline valids and state; taps_in_use to 16
// ----------------------------------------------------------------------------
`default_nettype none

module full_linear_convolution
  import flc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  flc_in_t          item,
  output logic             result_valid,
  input  logic             result_ready,
  output flc_out_t         result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]     taps_in_use;
  logic [CMP_W-1:0]     taps_cmp;
  logic [TAP_CNT_W-1:0] taps_eff;

  flc_state_t           state;
  flc_state_t           state_next;
  logic [TAP_CNT_W-1:0] flush_cnt;
  logic [TAP_CNT_W-1:0] flush_cnt_next;

  logic accept;
  logic load;
  logic samp;
  logic flush_step;
  logic issue;
  logic issue_last;
  logic start_flush;
  logic s0_valid;
  logic s0_last;
  logic s0_ready;
  logic tree_in_ready;

  logic signed [SAMPLE_BITS-1:0] chain    [MAX_TAPS+1];
  logic signed [PROD_W-1:0]      products [MAX_TAPS];
  logic signed [OUT_W-1:0]       leaves   [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= CFG_W'(TAPS_RESET);
    end else if (cfg_we) begin
      taps_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    taps_cmp = CMP_W'(taps_in_use);
    if (taps_cmp == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (taps_cmp > CMP_W'(MAX_TAPS)) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = TAP_CNT_W'(taps_cmp);
    end
  end

  // output decode of the flush sequencer
  always_comb begin
    item_ready = 1'b0;
    flush_step = 1'b0;
    unique case (state)
      ST_RUN: begin
        item_ready = s0_ready;
      end
      ST_FLUSH: begin
        flush_step = s0_ready;
      end
      default: begin
        item_ready = 1'b0;
        flush_step = 1'b0;
      end
    endcase
  end

  assign accept      = item_valid && item_ready;
  assign load        = accept && (item.action == ACT_LOAD);
  assign samp        = accept && (item.action == ACT_SAMPLE);
  assign issue       = samp || flush_step;
  assign start_flush = samp && item.last_sample && (taps_eff != TAP_CNT_W'(1));
  assign issue_last  = samp ? (item.last_sample && (taps_eff == TAP_CNT_W'(1)))
                            : (flush_cnt == TAP_CNT_W'(1));

  always_comb begin
    state_next     = state;
    flush_cnt_next = flush_cnt;
    unique case (state)
      ST_RUN: begin
        if (start_flush) begin
          state_next     = ST_FLUSH;
          flush_cnt_next = taps_eff - TAP_CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (flush_step) begin
          flush_cnt_next = flush_cnt - TAP_CNT_W'(1);
          if (flush_cnt == TAP_CNT_W'(1)) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      flush_cnt <= '0;
    end else begin
      state     <= state_next;
      flush_cnt <= flush_cnt_next;
    end
  end

  // product register stage
  assign s0_ready = !s0_valid || tree_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (issue) begin
      s0_valid <= 1'b1;
    end else if (tree_in_ready) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s0_last <= issue_last;
    end
  end

  assign chain[0] = flush_step ? '0 : item.value;

  genvar j;
  generate
    for (j = 0; j < MAX_TAPS; j++) begin : g_cell
      flc_cell_ctl_t ctl;

      assign ctl.issue   = issue;
      assign ctl.clear   = issue && issue_last;
      assign ctl.tap_we  = load && (32'(item.tap_index) == j);
      assign ctl.use_tap = TAP_CNT_W'(j) < taps_eff;

      flc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .tap_wdata  (item.value),
        .sample_in  (chain[j]),
        .sample_out (chain[j+1]),
        .product    (products[j])
      );

      assign leaves[j] = fit_out(products[j]);
    end
  endgenerate

  flc_sum_tree u_sum_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .in_last   (s0_last),
    .leaves    (leaves),
    .in_ready  (tree_in_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

`ifndef ASSERT_OFF
  a_flush_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (flush_cnt != '0) && (flush_cnt < TAP_CNT_W'(MAX_TAPS)))
    else $error("flush count out of range");

  a_end_returns_run: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (state == ST_RUN))
    else $error("sequencer not back in run after final element");

  a_history_cleared: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (chain[1] == '0))
    else $error("history not cleared after final element");

  a_no_item_in_flush: assert property (@(posedge clk) disable iff (rst)
    flush_step |-> !accept)
    else $error("item transfer during flush");
`endif

endmodule

`default_nettype wire

FILE: hdl/flc_cell.sv
// ----------------------------------------------------------------------------
// flc_cell
// One tap cell: holds a kernel tap and one history sample, forms the
// registered product of its tap and its incoming sample (zero if the tap is unused).
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cell
  import flc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  flc_cell_ctl_t                 ctl,
  input  logic signed [SAMPLE_BITS-1:0] tap_wdata,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic signed [PROD_W-1:0]      product
);

  logic signed [SAMPLE_BITS-1:0] tap;

  always_ff @(posedge clk) begin
    if (ctl.tap_we) begin
      tap <= tap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sample_out <= '0;
    end else if (ctl.issue) begin
      sample_out <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      if (ctl.use_tap) begin
        product <= PROD_W'(tap) * PROD_W'(sample_in);
      end else begin
        product <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/flc_sum_tree.sv
// ----------------------------------------------------------------------------
// flc_sum_tree
// Registered binary adder tree over the cell products, one level per stage,
// with per-level valid and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_sum_tree
  import flc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_last,
  input  logic signed [OUT_W-1:0] leaves [MAX_TAPS],
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output flc_out_t                out_data
);

  logic signed [OUT_W-1:0] leaf [TREE_LEAVES];
  logic signed [OUT_W-1:0] node [1:TREE_LEAVES-1];
  logic                    lvl_valid [0:TREE_LEVELS];
  logic                    lvl_last  [0:TREE_LEVELS];
  logic                    lvl_ready [1:TREE_LEVELS+1];

  genvar i, k, s;

  generate
    for (i = 0; i < TREE_LEAVES; i++) begin : g_leaf
      if (i < MAX_TAPS) begin : g_live
        assign leaf[i] = leaves[i];
      end else begin : g_pad
        assign leaf[i] = '0;
      end
    end
  endgenerate

  assign lvl_valid[0]             = in_valid;
  assign lvl_last[0]              = in_last;
  assign lvl_ready[TREE_LEVELS+1] = out_ready;

  generate
    for (s = 1; s <= TREE_LEVELS; s++) begin : g_stage
      assign lvl_ready[s] = !lvl_valid[s] || lvl_ready[s+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          lvl_valid[s] <= 1'b0;
        end else if (lvl_ready[s]) begin
          lvl_valid[s] <= lvl_valid[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (lvl_ready[s]) begin
          lvl_last[s] <= lvl_last[s-1];
        end
      end
    end
  endgenerate

  generate
    for (k = 1; k < TREE_LEAVES; k++) begin : g_node
      localparam int STG = TREE_LEVELS - ($clog2(k + 1) - 1);
      if (2 * k >= TREE_LEAVES) begin : g_from_leaf
        always_ff @(posedge clk) begin
          if (lvl_ready[STG]) begin
            node[k] <= leaf[2*k-TREE_LEAVES] + leaf[2*k+1-TREE_LEAVES];
          end
        end
      end else begin : g_from_node
        always_ff @(posedge clk) begin
          if (lvl_ready[STG]) begin
            node[k] <= node[2*k] + node[2*k+1];
          end
        end
      end
    end
  endgenerate

  assign in_ready             = lvl_ready[1];
  assign out_valid            = lvl_valid[TREE_LEVELS];
  assign out_data.conv_value  = node[1];
  assign out_data.last_result = lvl_last[TREE_LEVELS];

endmodule

`default_nettype wire
